/* rtl/nsv_pkg.sv */
// nsv_pkg: shared types and constants for the nearest smaller value unit.
// Used by the channel interfaces, the cell row and the top level.
package nsv_pkg;

  localparam int MAX_LEN    = 1024;
  localparam int VALUE_BITS = 30;
  localparam int POS_W      = 11;
  localparam int CNT_W      = $clog2(MAX_LEN + 1);

  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_LEN);
  localparam logic [POS_W-1:0] MAX_POS = POS_W'(MAX_LEN);

  typedef logic [VALUE_BITS-1:0] value_t;
  typedef logic [POS_W-1:0]      pos_t;
  typedef logic [CNT_W-1:0]      cnt_t;

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_t;

  // Shift command broadcast to every cell of the stack row.
  typedef struct packed {
    logic push;
    logic pop;
  } shift_ctrl_t;

endpackage

/* rtl/nsv_if.sv */
// nsv_in_if / nsv_out_if: valid/ready channels of the nearest smaller value unit.
// Depends on nsv_pkg for the payload types.
interface nsv_in_if;
  import nsv_pkg::*;

  logic   valid;
  logic   ready;
  value_t sample_value;
  logic   end_of_sequence;

  modport source (output valid, sample_value, end_of_sequence, input ready);
  modport sink   (input valid, sample_value, end_of_sequence, output ready);
endinterface

interface nsv_out_if;
  import nsv_pkg::*;

  logic valid;
  logic ready;
  pos_t nearest_position;
  logic length_overflow;

  modport source (output valid, nearest_position, length_overflow, input ready);
  modport sink   (input valid, nearest_position, length_overflow, output ready);
endinterface

/* rtl/nsv_cell.sv */
// nsv_cell: one stack slot holding a (value, position) pair.
// Takes the upper neighbor's pair on push, the lower one's on pop. Depends on nsv_pkg.
module nsv_cell (
  input  logic                clk,
  input  nsv_pkg::shift_ctrl_t ctrl,
  input  nsv_pkg::value_t     above_value,
  input  nsv_pkg::pos_t       above_pos,
  input  nsv_pkg::value_t     below_value,
  input  nsv_pkg::pos_t       below_pos,
  output nsv_pkg::value_t     cell_value,
  output nsv_pkg::pos_t       cell_pos
);
  import nsv_pkg::*;

  value_t value_r;
  pos_t   pos_r;

  always_ff @(posedge clk) begin
    if (ctrl.push) begin
      value_r <= above_value;
      pos_r   <= above_pos;
    end else if (ctrl.pop) begin
      value_r <= below_value;
      pos_r   <= below_pos;
    end
  end

  assign cell_value = value_r;
  assign cell_pos   = pos_r;

endmodule

/* rtl/nsv_stack.sv */
// nsv_stack: row of MAX_LEN nsv_cell slots forming a shift stack, top at cell 0.
// Depends on nsv_pkg and nsv_cell.
module nsv_stack (
  input  logic                 clk,
  input  nsv_pkg::shift_ctrl_t ctrl,
  input  nsv_pkg::value_t      push_value,
  input  nsv_pkg::pos_t        push_pos,
  output nsv_pkg::value_t      top_value,
  output nsv_pkg::pos_t        top_pos
);
  import nsv_pkg::*;

  value_t cell_value [MAX_LEN];
  pos_t   cell_pos   [MAX_LEN];

  for (genvar i = 0; i < MAX_LEN; i++) begin : g_cell
    value_t up_value, dn_value;
    pos_t   up_pos, dn_pos;

    if (i == 0) begin : g_top
      assign up_value = push_value;
      assign up_pos   = push_pos;
    end else begin : g_mid_up
      assign up_value = cell_value[i-1];
      assign up_pos   = cell_pos[i-1];
    end

    // bottom slot has nothing below it; its content is dead after a pop
    if (i == MAX_LEN - 1) begin : g_bottom
      assign dn_value = cell_value[i];
      assign dn_pos   = cell_pos[i];
    end else begin : g_mid_dn
      assign dn_value = cell_value[i+1];
      assign dn_pos   = cell_pos[i+1];
    end

    nsv_cell u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .above_value(up_value),
      .above_pos  (up_pos),
      .below_value(dn_value),
      .below_pos  (dn_pos),
      .cell_value (cell_value[i]),
      .cell_pos   (cell_pos[i])
    );
  end

  assign top_value = cell_value[0];
  assign top_pos   = cell_pos[0];

endmodule

/* rtl/nearest_smaller_value_stack_unit.sv */
// Nearest smaller value unit, top level: control sequencer and output register.
// Depends on nsv_pkg, nsv_in_if / nsv_out_if and nsv_stack.
//
// For every input value this unit returns the 1-based position, within the current
// sequence, of the nearest earlier value that is strictly smaller (0 if none). The
// stack lives in a row of 1024 shift cells with its top in the first cell; one entry
// is popped per clock until the top is smaller than the item or the stack is empty,
// then the result is registered. Every entry is popped at most once. A new item is
// taken only when the previous one has been answered; the result sits in an output
// register, so a stalled result channel holds up the unit only when that register
// is still full at the end of the next item. The item flagged end_of_sequence closes
// the sequence: the stack and position counter clear behind it. Items beyond 1024 in
// one sequence report with length_overflow set and are pushed only while the stack
// has room.
module nearest_smaller_value_stack_unit (
  input  logic       clk,
  input  logic       rst_n,
  nsv_in_if.sink     in_ch,
  nsv_out_if.source  out_ch
);
  import nsv_pkg::*;

  state_t      state_r, state_nxt;
  cnt_t        cnt_r, cnt_nxt;       // stack depth
  cnt_t        pcnt_r, pcnt_nxt;     // items seen in this sequence
  value_t      val_r;
  pos_t        pos_r;
  logic        last_r;
  logic        over_r;
  logic        out_valid_r, out_valid_nxt;
  pos_t        out_pos_r;
  logic        out_over_r;

  value_t      top_value;
  pos_t        top_pos;
  shift_ctrl_t ctrl;
  logic        in_xfer;
  logic        pop_hit;
  logic        finish;
  logic        out_free;

  nsv_stack u_stack (
    .clk       (clk),
    .ctrl      (ctrl),
    .push_value(val_r),
    .push_pos  (pos_r),
    .top_value (top_value),
    .top_pos   (top_pos)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_xfer) state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (finish) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs and datapath control
  always_comb begin
    in_xfer   = in_ch.valid && (state_r == ST_IDLE);
    out_free  = !out_valid_r || out_ch.ready;
    pop_hit   = (cnt_r != '0) && (top_value >= val_r);
    ctrl.pop  = (state_r == ST_SCAN) && pop_hit;
    finish    = (state_r == ST_SCAN) && !pop_hit && out_free;
    ctrl.push = finish && (cnt_r < MAX_CNT);

    cnt_nxt = cnt_r;
    if (ctrl.pop) begin
      cnt_nxt = cnt_r - cnt_t'(1);
    end else if (finish) begin
      if (last_r)          cnt_nxt = '0;
      else if (ctrl.push)  cnt_nxt = cnt_r + cnt_t'(1);
    end

    pcnt_nxt = pcnt_r;
    if (in_xfer && (pcnt_r < MAX_CNT)) pcnt_nxt = pcnt_r + cnt_t'(1);
    else if (finish && last_r)         pcnt_nxt = '0;

    out_valid_nxt = out_valid_r;
    if (finish)            out_valid_nxt = 1'b1;
    else if (out_ch.ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      pcnt_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      pcnt_r      <= pcnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // item and result payload
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      val_r  <= in_ch.sample_value;
      last_r <= in_ch.end_of_sequence;
      if (pcnt_r < MAX_CNT) begin
        pos_r  <= POS_W'(pcnt_r + cnt_t'(1));
        over_r <= 1'b0;
      end else begin
        pos_r  <= MAX_POS;
        over_r <= 1'b1;
      end
    end
    if (finish) begin
      out_pos_r  <= (cnt_r != '0) ? top_pos : '0;
      out_over_r <= over_r;
    end
  end

  assign in_ch.ready             = (state_r == ST_IDLE);
  assign out_ch.valid            = out_valid_r;
  assign out_ch.nearest_position = out_pos_r;
  assign out_ch.length_overflow  = out_over_r;

  a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= MAX_CNT)
    else $error("stack depth beyond capacity");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.pop |-> (cnt_r != '0) && !ctrl.push)
    else $error("pop on empty stack or with push");

  a_finish_lands: assert property (@(posedge clk) disable iff (!rst_n)
    finish |=> out_valid_r && (state_r == ST_IDLE))
    else $error("result not registered after finish");

  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    finish && last_r |=> (cnt_r == '0) && (pcnt_r == '0))
    else $error("sequence end did not clear stack");

endmodule
